// ----- sv/ppm_pkg.sv -----
package ppm_pkg;

    // Number format
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Derived datapath widths
    localparam int PROD_W = 2 * COORD_WIDTH;          // one coefficient product
    localparam int SUM_W  = PROD_W + 2;               // three-term dot product
    localparam int W_W    = SUM_W - FRAC_BITS;        // floored divisor
    localparam int Q_W    = COORD_WIDTH + 1;          // quotient bits developed
    localparam int DIV_W  = SUM_W + Q_W;              // divider compare width

    localparam int QUEUE_DEPTH_DEF = 4;

    // APB register file
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ROW_ONE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_TWO     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRANSLATION = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PERSPECTIVE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOMOG_SCALE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NEAR_CLIP   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic signed [COORD_WIDTH-1:0] FIX_ONE =
        COORD_WIDTH'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
    } ppm_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_out;
        logic signed [COORD_WIDTH-1:0] y_out;
        logic [1:0]                    status;
    } ppm_out_t;

    // Matrix as seen by the datapath
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] m11;
        logic signed [COORD_WIDTH-1:0] m12;
        logic signed [COORD_WIDTH-1:0] m21;
        logic signed [COORD_WIDTH-1:0] m22;
        logic signed [COORD_WIDTH-1:0] dx;
        logic signed [COORD_WIDTH-1:0] dy;
        logic signed [COORD_WIDTH-1:0] m13;
        logic signed [COORD_WIDTH-1:0] m23;
        logic signed [COORD_WIDTH-1:0] m33;
        logic                          clip;
    } ppm_cfg_t;

    // Classified point handed from front to back
    typedef struct packed {
        logic signed [SUM_W-1:0] ax;
        logic signed [SUM_W-1:0] ay;
        logic                    wneg;
        logic [W_W-1:0]          wmag;
        logic                    div0;
    } ppm_work_t;

    // One divider stage
    typedef struct packed {
        logic [SUM_W-1:0] rx;
        logic [SUM_W-1:0] ry;
        logic [Q_W-1:0]   qx;
        logic [Q_W-1:0]   qy;
        logic [W_W-1:0]   wmag;
        logic             negx;
        logic             negy;
        logic             ovfx;
        logic             ovfy;
        logic             div0;
    } ppm_div_t;

endpackage

// ----- sv/projective_point_mapper.sv -----
// Throughput: one point per cycle, less when result_ready holds the output and the queue fills;
// a 33-stage pipelined restoring divider and six parallel 32x32 multipliers carry it,
// and a queue of QUEUE_DEPTH entries (4 by default) parts front from back.
// Reset (rst_n low, asynchronous) empties the pipes and the queue and loads the
// identity matrix with near clipping on.
module projective_point_mapper #(
    parameter int QUEUE_DEPTH = ppm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            point_valid,
    output logic                            point_ready,
    input  ppm_pkg::ppm_in_t                point,
    output logic                            result_valid,
    input  logic                            result_ready,
    output ppm_pkg::ppm_out_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ppm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ppm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import ppm_pkg::*;

    ppm_cfg_t                            cfg;
    logic                                push, pop, head_valid;
    ppm_work_t                           push_data, head_data;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_level;

    ppm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppm_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .cfg         (cfg),
        .q_level     (q_level),
        .push        (push),
        .push_data   (push_data)
    );

    ppm_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .level      (q_level)
    );

    ppm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- sv/ppm_regs.sv -----
module ppm_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ppm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ppm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output ppm_pkg::ppm_cfg_t                cfg
);
    import ppm_pkg::*;

    logic [63:0] row_one_reg;
    logic [63:0] row_two_reg;
    logic [63:0] translation_reg;
    logic [63:0] perspective_reg;
    logic [31:0] homog_scale_reg;
    logic        near_clip_reg;

    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_one_reg     <= 64'h0001_0000_0000_0000;
            row_two_reg     <= 64'h0000_0000_0001_0000;
            translation_reg <= '0;
            perspective_reg <= '0;
            homog_scale_reg <= 32'h0001_0000;
            near_clip_reg   <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ROW_ONE:     row_one_reg     <= pwdata;
                REG_ROW_TWO:     row_two_reg     <= pwdata;
                REG_TRANSLATION: translation_reg <= pwdata;
                REG_PERSPECTIVE: perspective_reg <= pwdata;
                REG_HOMOG_SCALE: homog_scale_reg <= pwdata[31:0];
                REG_NEAR_CLIP:   near_clip_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_ROW_ONE:     prdata = row_one_reg;
            REG_ROW_TWO:     prdata = row_two_reg;
            REG_TRANSLATION: prdata = translation_reg;
            REG_PERSPECTIVE: prdata = perspective_reg;
            REG_HOMOG_SCALE: prdata = {32'd0, homog_scale_reg};
            REG_NEAR_CLIP:   prdata = {63'd0, near_clip_reg};
            default:         prdata = '0;
        endcase
    end

    // Coefficients, each a 32-bit field resized to the coordinate width
    assign cfg.m11  = COORD_WIDTH'($signed(row_one_reg[63:32]));
    assign cfg.m12  = COORD_WIDTH'($signed(row_one_reg[31:0]));
    assign cfg.m21  = COORD_WIDTH'($signed(row_two_reg[63:32]));
    assign cfg.m22  = COORD_WIDTH'($signed(row_two_reg[31:0]));
    assign cfg.dx   = COORD_WIDTH'($signed(translation_reg[63:32]));
    assign cfg.dy   = COORD_WIDTH'($signed(translation_reg[31:0]));
    assign cfg.m13  = COORD_WIDTH'($signed(perspective_reg[63:32]));
    assign cfg.m23  = COORD_WIDTH'($signed(perspective_reg[31:0]));
    assign cfg.m33  = COORD_WIDTH'($signed(homog_scale_reg));
    assign cfg.clip = near_clip_reg;

endmodule

// ----- sv/ppm_front.sv -----
module ppm_front #(
    parameter int QUEUE_DEPTH = ppm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              point_valid,
    output logic                              point_ready,
    input  ppm_pkg::ppm_in_t                  point,
    input  ppm_pkg::ppm_cfg_t                 cfg,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_level,
    output logic                              push,
    output ppm_pkg::ppm_work_t                push_data
);
    import ppm_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    logic                     valid_a_reg;
    logic signed [PROD_W-1:0] p11_reg, p21_reg, p12_reg, p22_reg, p13_reg, p23_reg;

    logic [LW:0]              used;
    logic                     take;
    logic signed [SUM_W-1:0]  ax, ay, wsum;
    logic signed [W_W-1:0]    wq, wsel;
    logic                     fast;

    // Credit check: queue entries plus the beat still in the multipliers
    assign used        = {1'b0, q_level} + (LW + 1)'(valid_a_reg);
    assign point_ready = used < (LW + 1)'(QUEUE_DEPTH);
    assign take        = point_valid && point_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_a_reg <= 1'b0;
        else
            valid_a_reg <= take;
    end

    // Multiplier stage, six lanes, operands sign-extended to the product width
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p11_reg <= PROD_W'(cfg.m11) * PROD_W'(point.x_in);
            p21_reg <= PROD_W'(cfg.m21) * PROD_W'(point.y_in);
            p12_reg <= PROD_W'(cfg.m12) * PROD_W'(point.x_in);
            p22_reg <= PROD_W'(cfg.m22) * PROD_W'(point.y_in);
            p13_reg <= PROD_W'(cfg.m13) * PROD_W'(point.x_in);
            p23_reg <= PROD_W'(cfg.m23) * PROD_W'(point.y_in);
        end
    end

    // Sums, divisor floor and near-plane classification
    always_comb
    begin
        ax   = SUM_W'(p11_reg) + SUM_W'(p21_reg) + (SUM_W'(cfg.dx) <<< FRAC_BITS);
        ay   = SUM_W'(p12_reg) + SUM_W'(p22_reg) + (SUM_W'(cfg.dy) <<< FRAC_BITS);
        wsum = SUM_W'(p13_reg) + SUM_W'(p23_reg) + (SUM_W'(cfg.m33) <<< FRAC_BITS);
        wq   = W_W'(wsum >>> FRAC_BITS);
        fast = (cfg.m13 == '0) && (cfg.m23 == '0) && (cfg.m33 == FIX_ONE);
        if (fast)
            wsel = W_W'(FIX_ONE);
        else if (cfg.clip && (wq[W_W-1] || (wq == '0)))
            wsel = W_W'(1);
        else
            wsel = wq;
        push_data.ax   = ax;
        push_data.ay   = ay;
        push_data.wneg = wsel[W_W-1];
        push_data.wmag = wsel[W_W-1] ? W_W'(-wsel) : wsel;
        push_data.div0 = (wsel == '0);
    end

    assign push = valid_a_reg;

endmodule

// ----- sv/ppm_queue.sv -----
module ppm_queue #(
    parameter int QUEUE_DEPTH = ppm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  ppm_pkg::ppm_work_t                push_data,
    input  logic                              pop,
    output logic                              head_valid,
    output ppm_pkg::ppm_work_t                head_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  level
);
    import ppm_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    ppm_work_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0]     count_reg;
    logic              do_pop;

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign level      = count_reg;
    assign do_pop     = pop && head_valid;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/ppm_back.sv -----
module ppm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ppm_pkg::ppm_work_t  head_data,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output ppm_pkg::ppm_out_t   result
);
    import ppm_pkg::*;

    localparam int N = Q_W;
    localparam logic [Q_W-1:0] MAXPOS = Q_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);

    // One restoring step on both lanes
    function automatic ppm_div_t div_step(ppm_div_t s, int unsigned bit_pos);
        ppm_div_t         r;
        logic [DIV_W-1:0] d;
        r = s;
        d = DIV_W'(s.wmag) << bit_pos;
        if (DIV_W'(s.rx) >= d)
        begin
            r.rx          = s.rx - SUM_W'(d);
            r.qx[bit_pos] = 1'b1;
        end
        if (DIV_W'(s.ry) >= d)
        begin
            r.ry          = s.ry - SUM_W'(d);
            r.qy[bit_pos] = 1'b1;
        end
        return r;
    endfunction

    // Truncated quotient to signed coordinate with clamping; top bit is the sat flag
    function automatic logic [COORD_WIDTH:0] clamp(logic [Q_W-1:0] q, logic ovf, logic neg);
        logic [COORD_WIDTH:0] r;
        if (!neg && (ovf || q > MAXPOS))
            r = {1'b1, COORD_WIDTH'(MAXPOS)};
        else if (neg && (ovf || q > MAXPOS + 1'b1))
            r = {1'b1, COORD_WIDTH'(MAXPOS + 1'b1)};
        else
            r = {1'b0, neg ? COORD_WIDTH'(-q) : COORD_WIDTH'(q)};
        return r;
    endfunction

    ppm_div_t           stage_reg [N+1];
    logic [N:0]         stage_valid_reg;
    logic               result_valid_reg;
    ppm_out_t           result_reg;
    logic               adv;
    ppm_div_t           load;
    logic [SUM_W-1:0]   magx, magy;
    logic [COORD_WIDTH:0] cx, cy;
    ppm_out_t           result_next;

    // Whole back pipe moves unless the output beat is held
    assign adv = !result_valid_reg || result_ready;
    assign pop = adv && head_valid;

    // Entry: magnitudes, signs and quotient range check
    always_comb
    begin
        magx = head_data.ax[SUM_W-1] ? SUM_W'(-head_data.ax) : head_data.ax;
        magy = head_data.ay[SUM_W-1] ? SUM_W'(-head_data.ay) : head_data.ay;
        load.rx   = magx;
        load.ry   = magy;
        load.qx   = '0;
        load.qy   = '0;
        load.wmag = head_data.wmag;
        load.negx = head_data.ax[SUM_W-1] ^ head_data.wneg;
        load.negy = head_data.ay[SUM_W-1] ^ head_data.wneg;
        load.ovfx = DIV_W'(magx) >= (DIV_W'(head_data.wmag) << Q_W);
        load.ovfy = DIV_W'(magy) >= (DIV_W'(head_data.wmag) << Q_W);
        load.div0 = head_data.div0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            stage_valid_reg  <= {stage_valid_reg[N-1:0], head_valid};
            result_valid_reg <= stage_valid_reg[N];
        end
    end

    // Divider stages, one quotient bit each, MSB first
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg[0] <= load;
            for (int k = 0; k < N; k++)
                stage_reg[k+1] <= div_step(stage_reg[k], N - 1 - k);
        end
    end

    // Final clamp and status
    always_comb
    begin
        cx = clamp(stage_reg[N].qx, stage_reg[N].ovfx, stage_reg[N].negx);
        cy = clamp(stage_reg[N].qy, stage_reg[N].ovfy, stage_reg[N].negy);
        if (stage_reg[N].div0)
        begin
            result_next.x_out  = '0;
            result_next.y_out  = '0;
            result_next.status = ST_DIV0;
        end
        else
        begin
            result_next.x_out  = cx[COORD_WIDTH-1:0];
            result_next.y_out  = cy[COORD_WIDTH-1:0];
            result_next.status = (cx[COORD_WIDTH] || cy[COORD_WIDTH]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/ppm_checker.sv -----
module ppm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input ppm_pkg::ppm_out_t  result
);
    import ppm_pkg::*;

    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // A held result beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // Divide by zero returns a zero point
    a_div0: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_DIV0 |-> result.x_out == '0 && result.y_out == '0)
        else $error("divide-by-zero beat with nonzero point");

    // Saturation leaves at least one coordinate on a limit
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_SAT |->
            result.x_out == CMAX || result.x_out == CMIN ||
            result.y_out == CMAX || result.y_out == CMIN)
        else $error("saturated beat without a clamped coordinate");

    // Nothing leaves while in reset
    a_rst: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

endmodule

bind projective_point_mapper ppm_checker u_ppm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
